>>> hdl/arb_pkg.sv
// ----------------------------------------------------------------------------
// arb_pkg
// Shared widths, types and helpers for the address range bitmap.
// ----------------------------------------------------------------------------
`default_nettype none

package arb_pkg;

  localparam int ADDR_BITS     = 16;
  localparam int WORD_BITS     = 32;
  localparam int OFF_BITS      = $clog2(WORD_BITS);
  localparam int WADDR_BITS    = ADDR_BITS - OFF_BITS;
  localparam int WORD_COUNT    = 2 ** WADDR_BITS;
  localparam int FIELD_BITS    = 16;
  localparam int IN_DATA_BITS  = 3 * FIELD_BITS;
  localparam int OUT_DATA_BITS = ((FIELD_BITS + 1 + 7) / 8) * 8;

  localparam logic OP_MARK = 1'b0;
  localparam logic OP_TEST = 1'b1;

  typedef logic [WADDR_BITS-1:0] waddr_t;
  typedef logic [WORD_BITS-1:0]  word_t;
  typedef logic [OFF_BITS-1:0]   off_t;
  typedef logic [ADDR_BITS-1:0]  addr_t;

  typedef struct packed {
    logic   en;
    waddr_t addr;
    word_t  data;
  } mem_wr_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TEST,
    ST_HEAD,
    ST_FILL,
    ST_TAIL
  } state_e;

  // bits lo..hi of one word set
  function automatic word_t span_mask(off_t lo, off_t hi);
    word_t ones;
    ones = '1;
    return (ones >> (off_t'(WORD_BITS - 1) - hi)) & (ones << lo);
  endfunction

endpackage

`default_nettype wire

>>> hdl/arb_ram.sv
// ----------------------------------------------------------------------------
// arb_ram
// Bitmap word store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module arb_ram (
  input  wire logic             clk_i,
  input  wire arb_pkg::mem_wr_t wr_i,
  input  wire logic             rd_en_i,
  input  wire arb_pkg::waddr_t  rd_addr_i,
  output      arb_pkg::word_t   rd_data_o
);

  arb_pkg::word_t mem_q [arb_pkg::WORD_COUNT];
  arb_pkg::word_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

>>> hdl/address_range_bitmap_core.sv
// ----------------------------------------------------------------------------
// address_range_bitmap_core
// Bitmap with one bit per address: mark items set an inclusive address range,
// test items return the bit of one address.
//
//   channel   dir  tdata (low bit up)                              tuser
//   s_axis    in   first_address, last_address, query_address      operation
//   m_axis    out  included, tested_address, zero pad              -
//
// test: the word is read from the store and its result registered in ST_TEST
//   once the output is free; the next word is accepted only back in ST_IDLE.
// mark: ST_HEAD writes the first word, ST_FILL the whole words between, ST_TAIL
//   the last; one memory word is written per cycle, reversed ranges write none.
// after reset the store is cleared one word a cycle, with s_axis_tready_o low;
//   a stalled output holds a pending test in place.
// ----------------------------------------------------------------------------
`default_nettype none

module address_range_bitmap_core (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid_i,
  output      logic                              s_axis_tready_o,
  // first_address, last_address, query_address
  input  wire logic [arb_pkg::IN_DATA_BITS-1:0]  s_axis_tdata_i,
  // operation
  input  wire logic                              s_axis_tuser_i,
  output      logic                              m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  // included, tested_address, zero pad
  output      logic [arb_pkg::OUT_DATA_BITS-1:0] m_axis_tdata_o
);

  localparam int FB = arb_pkg::FIELD_BITS;

  arb_pkg::state_e  state_q, state_d;
  arb_pkg::waddr_t  clr_q, clr_d;
  arb_pkg::waddr_t  cur_q, cur_d;
  arb_pkg::waddr_t  fq_q, lq_q;
  arb_pkg::off_t    fr_q, lr_q, qoff_q;
  logic [FB-1:0]    qaddr_q;
  logic             out_valid_q;
  logic             out_incl_q;
  logic [FB-1:0]    out_addr_q;

  arb_pkg::mem_wr_t wr;
  logic             rd_en;
  arb_pkg::waddr_t  rd_addr;
  arb_pkg::word_t   rd_data;
  logic             accept;
  logic             out_load;

  logic [FB-1:0]    in_first, in_last, in_query;
  arb_pkg::addr_t   first_a, last_a, query_a;

  assign in_first = s_axis_tdata_i[FB-1:0];
  assign in_last  = s_axis_tdata_i[2*FB-1:FB];
  assign in_query = s_axis_tdata_i[3*FB-1:2*FB];
  assign first_a  = in_first[arb_pkg::ADDR_BITS-1:0];
  assign last_a   = in_last[arb_pkg::ADDR_BITS-1:0];
  assign query_a  = in_query[arb_pkg::ADDR_BITS-1:0];

  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  arb_ram u_ram (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  always_comb begin
    state_d         = state_q;
    clr_d           = clr_q;
    cur_d           = cur_q;
    wr              = '0;
    rd_en           = 1'b0;
    rd_addr         = lq_q;
    s_axis_tready_o = 1'b0;
    out_load        = 1'b0;
    case (state_q)
      arb_pkg::ST_CLEAR: begin
        wr.en   = 1'b1;
        wr.addr = clr_q;
        wr.data = '0;
        clr_d   = arb_pkg::waddr_t'(clr_q + 1'b1);
        if (clr_q == '1) begin
          state_d = arb_pkg::ST_IDLE;
        end
      end
      arb_pkg::ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          if (s_axis_tuser_i == arb_pkg::OP_TEST) begin
            rd_en   = 1'b1;
            rd_addr = query_a[arb_pkg::ADDR_BITS-1:arb_pkg::OFF_BITS];
            state_d = arb_pkg::ST_TEST;
          end else if (first_a <= last_a) begin
            rd_en   = 1'b1;
            rd_addr = first_a[arb_pkg::ADDR_BITS-1:arb_pkg::OFF_BITS];
            state_d = arb_pkg::ST_HEAD;
          end
        end
      end
      arb_pkg::ST_TEST: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_load = 1'b1;
          state_d  = arb_pkg::ST_IDLE;
        end
      end
      arb_pkg::ST_HEAD: begin
        wr.en   = 1'b1;
        wr.addr = fq_q;
        if (fq_q == lq_q) begin
          wr.data = rd_data | arb_pkg::span_mask(fr_q, lr_q);
          state_d = arb_pkg::ST_IDLE;
        end else begin
          wr.data = rd_data | arb_pkg::span_mask(fr_q, '1);
          rd_en   = 1'b1;
          rd_addr = lq_q;
          cur_d   = arb_pkg::waddr_t'(fq_q + 1'b1);
          if (arb_pkg::waddr_t'(fq_q + 1'b1) == lq_q) begin
            state_d = arb_pkg::ST_TAIL;
          end else begin
            state_d = arb_pkg::ST_FILL;
          end
        end
      end
      arb_pkg::ST_FILL: begin
        wr.en   = 1'b1;
        wr.addr = cur_q;
        wr.data = '1;
        cur_d   = arb_pkg::waddr_t'(cur_q + 1'b1);
        if (arb_pkg::waddr_t'(cur_q + 1'b1) == lq_q) begin
          state_d = arb_pkg::ST_TAIL;
        end
      end
      arb_pkg::ST_TAIL: begin
        wr.en   = 1'b1;
        wr.addr = lq_q;
        wr.data = rd_data | arb_pkg::span_mask('0, lr_q);
        state_d = arb_pkg::ST_IDLE;
      end
      default: begin
        state_d = arb_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= arb_pkg::ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (accept) begin
      fq_q    <= first_a[arb_pkg::ADDR_BITS-1:arb_pkg::OFF_BITS];
      fr_q    <= first_a[arb_pkg::OFF_BITS-1:0];
      lq_q    <= last_a[arb_pkg::ADDR_BITS-1:arb_pkg::OFF_BITS];
      lr_q    <= last_a[arb_pkg::OFF_BITS-1:0];
      qoff_q  <= query_a[arb_pkg::OFF_BITS-1:0];
      qaddr_q <= in_query;
    end
    if (out_load) begin
      out_incl_q <= rd_data[qoff_q];
      out_addr_q <= qaddr_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(arb_pkg::OUT_DATA_BITS - FB - 1){1'b0}}, out_addr_q, out_incl_q};

endmodule

`default_nettype wire

>>> verif/address_range_bitmap_checker.sv
// ----------------------------------------------------------------------------
// address_range_bitmap_checker
// Watches both streams of the address range bitmap core, keeps a shadow
// bitmap updated by every accepted mark word, predicts the answer of every
// accepted test word and compares it with the words leaving the block.
// ----------------------------------------------------------------------------

module address_range_bitmap_checker
  import arb_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     s_tvalid_i,
  input  wire logic                     s_tready_i,
  // first_address, last_address, query_address
  input  wire logic [IN_DATA_BITS-1:0]  s_tdata_i,
  // operation
  input  wire logic                     s_tuser_i,
  input  wire logic                     m_tvalid_i,
  input  wire logic                     m_tready_i,
  // included, tested_address, zero pad
  input  wire logic [OUT_DATA_BITS-1:0] m_tdata_i,
  output int                            failures_o,
  output int                            pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic                  included;
    logic [FIELD_BITS-1:0] tested_address;
  } lookup_t;

  word_t   shadow_bitmap [WORD_COUNT];
  lookup_t lookups_due [$];
  int      fail_count;

  always @(posedge clk_i or negedge rst_ni) begin : watch
    lookup_t         due;
    lookup_t         seen;
    addr_t           first_addr;
    addr_t           last_addr;
    addr_t           query_addr;
    int              first_q;
    int              last_q;
    int              lo;
    int              hi;
    longint unsigned mask;
    if (!rst_ni) begin
      foreach (shadow_bitmap[i]) shadow_bitmap[i] = '0;
      lookups_due.delete();
      fail_count = 0;
      pending_o  <= 0;
      failures_o <= 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        seen.included       = m_tdata_i[0];
        seen.tested_address = m_tdata_i[FIELD_BITS:1];
        if (lookups_due.size() == 0) begin
          $error("unexpected result word: included %0d, tested_address %0h",
                 seen.included, seen.tested_address);
          fail_count++;
        end else begin
          due = lookups_due.pop_front();
          if (seen.included !== due.included) begin
            $error("included: expected %0d, actual %0d", due.included, seen.included);
            fail_count++;
          end
          if (seen.tested_address !== due.tested_address) begin
            $error("tested_address: expected %0h, actual %0h",
                   due.tested_address, seen.tested_address);
            fail_count++;
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        first_addr = addr_t'(s_tdata_i[FIELD_BITS-1:0]);
        last_addr  = addr_t'(s_tdata_i[2*FIELD_BITS-1:FIELD_BITS]);
        query_addr = addr_t'(s_tdata_i[3*FIELD_BITS-1:2*FIELD_BITS]);
        if (s_tuser_i == OP_TEST) begin
          due.included = shadow_bitmap[(query_addr / WORD_BITS) % WORD_COUNT]
                                      [query_addr % WORD_BITS];
          due.tested_address = s_tdata_i[3*FIELD_BITS-1:2*FIELD_BITS];
          lookups_due.push_back(due);
        end else if (first_addr <= last_addr) begin
          // reversed ranges leave the bitmap untouched
          first_q = first_addr / WORD_BITS;
          last_q  = last_addr / WORD_BITS;
          for (int q = first_q; q <= last_q; q++) begin
            lo   = (q == first_q) ? first_addr % WORD_BITS : 0;
            hi   = (q == last_q) ? last_addr % WORD_BITS : WORD_BITS - 1;
            mask = ((64'd1 << (hi - lo + 1)) - 64'd1) << lo;
            shadow_bitmap[q % WORD_COUNT] |= word_t'(mask);
          end
        end
      end
      pending_o  <= lookups_due.size();
      failures_o <= fail_count;
    end
  end

endmodule

>>> verif/address_range_bitmap_core_test.sv
// ----------------------------------------------------------------------------
// address_range_bitmap_core_test
// Drives mark and test words into the address range bitmap core: a directed
// set of edge ranges and addresses, then random ranges with lookups aimed at
// their ends, under bursty input and a stalling output. The checker beside
// the block predicts every answer; this module gives the verdict.
// ----------------------------------------------------------------------------

module address_range_bitmap_core_test;

  import arb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_WAIT  = 2200;
  localparam int RANDOM_WORDS = 1900;

  logic                     clk      = 1'b0;
  logic                     rst_n    = 1'b0;
  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  logic [IN_DATA_BITS-1:0]  s_tdata  = '0;
  logic                     s_tuser  = OP_MARK;
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_tdata;

  int failures;
  int pending;
  int cycle_count = 0;
  int burst_left  = 0;
  int ready_left  = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  address_range_bitmap_core DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  address_range_bitmap_checker checker_inst (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .s_tvalid_i (s_tvalid),
    .s_tready_i (s_tready),
    .s_tdata_i  (s_tdata),
    .s_tuser_i  (s_tuser),
    .m_tvalid_i (m_tvalid),
    .m_tready_i (m_tready),
    .m_tdata_i  (m_tdata),
    .failures_o (failures),
    .pending_o  (pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[address_range_bitmap_core] ERROR");
      $finish;
    end
  end

  // output side: ready and stall stretches of random length, picked at random
  always @(posedge clk) begin
    int unsigned pick;
    if (ready_left == 0) begin
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        m_tready   <= 1'b1;
        ready_left <= $urandom_range(1, 40);
      end else begin
        m_tready   <= 1'b0;
        ready_left <= (pick == 9) ? $urandom_range(10, 30) : $urandom_range(1, 4);
      end
    end else begin
      ready_left <= ready_left - 1;
    end
  end

  task automatic send_word(input logic op, input addr_t first_addr, input addr_t last_addr,
                           input addr_t query_addr);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= {query_addr, last_addr, first_addr};
    s_tuser  <= op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic wait_drained();
    s_tvalid   <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    int unsigned  pick;
    addr_t        first_addr;
    addr_t        last_addr;
    addr_t        query_addr;
    addr_t        prev_first;
    addr_t        prev_last;
    logic [16:0]  end_sum;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // empty bitmap at both ends
    send_word(OP_TEST, 16'hFFFF, 16'hFFFF, 16'h0000);
    send_word(OP_TEST, 16'h0000, 16'h0000, 16'hFFFF);
    // one-address ranges at both ends
    send_word(OP_MARK, 16'h0000, 16'h0000, 16'hFFFF);
    send_word(OP_TEST, 16'hFFFF, 16'h0000, 16'h0000);
    send_word(OP_TEST, 16'h0000, 16'hFFFF, 16'h0001);
    send_word(OP_MARK, 16'hFFFF, 16'hFFFF, 16'h0000);
    send_word(OP_TEST, 16'h0000, 16'h0000, 16'hFFFF);
    send_word(OP_TEST, 16'h0000, 16'h0000, 16'hFFFE);
    // reversed range marks nothing
    send_word(OP_MARK, 16'd1000, 16'd999, 16'h5A5A);
    send_word(OP_TEST, 16'h0000, 16'h0000, 16'd999);
    send_word(OP_TEST, 16'h0000, 16'h0000, 16'd1000);
    // range inside one word
    send_word(OP_MARK, 16'd37, 16'd45, 16'hA5A5);
    send_word(OP_TEST, 16'h1234, 16'h4321, 16'd36);
    send_word(OP_TEST, 16'h0000, 16'h0000, 16'd37);
    send_word(OP_TEST, 16'h0000, 16'h0000, 16'd45);
    send_word(OP_TEST, 16'h0000, 16'h0000, 16'd46);
    // range across several words
    send_word(OP_MARK, 16'd100, 16'd300, 16'h0000);
    send_word(OP_TEST, 16'h0000, 16'h0000, 16'd99);
    send_word(OP_TEST, 16'h0000, 16'h0000, 16'd100);
    send_word(OP_TEST, 16'h0000, 16'h0000, 16'd200);
    send_word(OP_TEST, 16'h0000, 16'h0000, 16'd300);
    send_word(OP_TEST, 16'h0000, 16'h0000, 16'd301);
    // two whole aligned words
    send_word(OP_MARK, 16'd512, 16'd575, 16'h0000);
    send_word(OP_TEST, 16'h0000, 16'h0000, 16'd511);
    send_word(OP_TEST, 16'h0000, 16'h0000, 16'd576);

    prev_first = 16'd512;
    prev_last  = 16'd575;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == RANDOM_WORDS / 2) wait_drained();
      first_addr = addr_t'($urandom);
      last_addr  = addr_t'($urandom);
      query_addr = addr_t'($urandom);
      pick       = $urandom_range(0, 99);
      if (pick < 35) begin
        if (pick < 3) end_sum = 17'(first_addr) + 17'($urandom_range(0, 4095));
        else if (pick < 6) end_sum = {1'b0, first_addr};
        else end_sum = 17'(first_addr) + 17'($urandom_range(0, 63));
        last_addr = end_sum[16] ? 16'hFFFF : end_sum[15:0];
        // occasionally flip the ends so the range is reversed
        if (pick >= 30 && first_addr != last_addr) begin
          {first_addr, last_addr} = {last_addr, first_addr};
        end
        prev_first = first_addr;
        prev_last  = last_addr;
        send_word(OP_MARK, first_addr, last_addr, query_addr);
      end else begin
        case ($urandom_range(0, 5))
          0: query_addr = prev_first - 16'd1;
          1: query_addr = prev_first;
          2: query_addr = prev_last;
          3: query_addr = prev_last + 16'd1;
          default: ;
        endcase
        send_word(OP_TEST, first_addr, last_addr, query_addr);
      end
    end

    // whole address space
    send_word(OP_MARK, 16'h0000, 16'hFFFF, addr_t'($urandom));
    for (int n = 0; n < 10; n++) begin
      send_word(OP_TEST, addr_t'($urandom), addr_t'($urandom), addr_t'($urandom));
    end

    wait_drained();
    repeat (SETTLE_WAIT) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("[address_range_bitmap_core] OK");
    end else begin
      $display("[address_range_bitmap_core] ERROR");
    end
    $finish;
  end

endmodule
